>>> rtl/core/tfs_pkg.sv
// Shared types and frame constants for the telemetry frame serializer.
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

   localparam int LaneCount = 9;
   localparam int AttCount  = 6;

   localparam logic ModeAttitude = 1'b0;
   localparam logic ModeMotion   = 1'b1;

   localparam logic [7:0] HdrFirst  = 8'hA5;
   localparam logic [7:0] HdrSecond = 8'h5A;
   localparam logic [7:0] TailByte  = 8'hAA;
   localparam logic [7:0] LenAtt    = 8'd16;
   localparam logic [7:0] LenMot    = 8'd22;
   localparam logic [7:0] TypeAtt   = 8'hA1;
   localparam logic [7:0] TypeMot   = 8'hA2;

   localparam logic [15:0] SignOffset = 16'h8000;

   localparam int IdxWidth = 5;
   localparam logic [IdxWidth-1:0] IdxHdrFirst  = 5'd0;
   localparam logic [IdxWidth-1:0] IdxHdrSecond = 5'd1;
   localparam logic [IdxWidth-1:0] IdxLen       = 5'd2;
   localparam logic [IdxWidth-1:0] IdxType      = 5'd3;
   localparam logic [IdxWidth-1:0] IdxDataStart = 5'd4;
   localparam logic [IdxWidth-1:0] IdxLastAtt   = 5'd17;
   localparam logic [IdxWidth-1:0] IdxLastMot   = 5'd23;

   typedef logic [15:0] word_type;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] value_0;
      logic signed [15:0] value_1;
      logic signed [15:0] value_2;
      logic signed [15:0] value_3;
      logic signed [15:0] value_4;
      logic signed [15:0] value_5;
      logic signed [15:0] value_6;
      logic signed [15:0] value_7;
      logic signed [15:0] value_8;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic                          mode;
      logic [LaneCount-1:0][15:0]    word;
      logic [7:0]                    checksum;
   } frame_type;

endpackage

`default_nettype wire

>>> rtl/core/tfs_if.sv
// Request and response channel interfaces of the telemetry frame serializer.
`timescale 1ns / 1ps
`default_nettype none

interface tfs_req_if;
   logic                     valid;
   logic                     ready;
   tfs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tfs_rsp_if;
   logic                     valid;
   logic                     ready;
   tfs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tfs_lane.sv
// One encoding lane: sign-magnitude conversion of a value and the sum of its two bytes.
`timescale 1ns / 1ps
`default_nettype none

module tfs_lane (
   input  wire logic signed [15:0] value,
   output tfs_pkg::word_type       word,
   output logic [7:0]              byte_sum
);
   import tfs_pkg::*;

   // A negative value becomes 0x8000 plus its magnitude, which is 0x8000 minus
   // the raw word modulo 2^16; the most negative value therefore wraps to zero.
   always_comb begin
      if (value[15]) begin
         word = SignOffset - word_type'(value);
      end else begin
         word = word_type'(value);
      end
      byte_sum = word[15:8] + word[7:0];
   end

endmodule

`default_nettype wire

>>> rtl/core/tfs_merge.sv
// Merging stage: gathers the lane results into a staged frame with its checksum.
`timescale 1ns / 1ps
`default_nettype none

module tfs_merge (
   input  wire logic               clock,
   input  wire logic               reset,
   tfs_req_if.sink                 req_if,
   input  wire tfs_pkg::word_type  lane_word [tfs_pkg::LaneCount],
   input  wire logic [7:0]         lane_sum [tfs_pkg::LaneCount],
   input  wire logic               take,
   output tfs_pkg::frame_type      pend_frame,
   output logic                    pend_valid
);
   import tfs_pkg::*;

   frame_type  pend_ff;
   frame_type  pend_in;
   logic       pend_valid_ff;
   logic       pend_valid_in;
   logic       accept;
   logic [7:0] checksum;

   // The staging slot frees up in the same cycle the emitter takes its frame.
   assign req_if.ready = !pend_valid_ff || take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      if (req_if.payload.mode == ModeMotion) begin
         checksum = LenMot + TypeMot;
      end else begin
         checksum = LenAtt + TypeAtt;
      end
      for (int i = 0; i < LaneCount; i++) begin
         if (i < AttCount || req_if.payload.mode == ModeMotion) begin
            checksum = checksum + lane_sum[i];
         end
      end
   end

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_in.mode     = req_if.payload.mode;
         pend_in.checksum = checksum;
         for (int i = 0; i < LaneCount; i++) begin
            pend_in.word[i] = lane_word[i];
         end
         pend_valid_in = 1'b1;
      end else if (take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

   assign pend_frame = pend_ff;
   assign pend_valid = pend_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/tfs_emit.sv
// Byte emitter: walks the active frame and drives one response byte per cycle while rsp_if.ready is high.
`timescale 1ns / 1ps
`default_nettype none

module tfs_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tfs_pkg::frame_type pend_frame,
   input  wire logic               pend_valid,
   output logic                    take,
   tfs_rsp_if.source               rsp_if
);
   import tfs_pkg::*;

   frame_type              active_ff;
   frame_type              active_in;
   logic                   active_valid_ff;
   logic                   active_valid_in;
   logic [IdxWidth-1:0]    idx_ff;
   logic [IdxWidth-1:0]    idx_in;
   logic [IdxWidth-1:0]    last_idx;
   logic [IdxWidth-1:0]    chk_idx;
   logic [IdxWidth-1:0]    data_pos;
   logic [3:0]             word_idx;
   word_type               sel_word;
   logic                   is_last;
   logic                   fire;
   logic [7:0]             out_byte;

   always_comb begin
      last_idx = (active_ff.mode == ModeMotion) ? IdxLastMot : IdxLastAtt;
      chk_idx  = last_idx - IdxWidth'(1);
      is_last  = (idx_ff == last_idx);
      data_pos = idx_ff - IdxDataStart;
      word_idx = data_pos[4:1];
      if (word_idx < LaneCount) begin
         sel_word = active_ff.word[word_idx];
      end else begin
         sel_word = '0;
      end

      priority if (idx_ff == IdxHdrFirst) begin
         out_byte = HdrFirst;
      end else if (idx_ff == IdxHdrSecond) begin
         out_byte = HdrSecond;
      end else if (idx_ff == IdxLen) begin
         out_byte = (active_ff.mode == ModeMotion) ? LenMot : LenAtt;
      end else if (idx_ff == IdxType) begin
         out_byte = (active_ff.mode == ModeMotion) ? TypeMot : TypeAtt;
      end else if (is_last) begin
         out_byte = TailByte;
      end else if (idx_ff == chk_idx) begin
         out_byte = active_ff.checksum;
      end else begin
         // High byte first within each word.
         out_byte = data_pos[0] ? sel_word[7:0] : sel_word[15:8];
      end
   end

   assign fire = active_valid_ff && rsp_if.ready;
   assign take = pend_valid && (!active_valid_ff || (fire && is_last));

   always_comb begin
      active_in       = active_ff;
      active_valid_in = active_valid_ff;
      idx_in          = idx_ff;
      if (take) begin
         active_in       = pend_frame;
         active_valid_in = 1'b1;
         idx_in          = '0;
      end else if (fire) begin
         if (is_last) begin
            active_valid_in = 1'b0;
            idx_in          = '0;
         end else begin
            idx_in = idx_ff + IdxWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_valid_ff <= 1'b0;
         idx_ff          <= '0;
      end else begin
         active_valid_ff <= active_valid_in;
         idx_ff          <= idx_in;
      end
      active_ff <= active_in;
   end

   assign rsp_if.valid             = active_valid_ff;
   assign rsp_if.payload.out_byte  = out_byte;
   assign rsp_if.payload.last_byte = is_last;

   a_idle_idx_zero : assert property (@(posedge clock) disable iff (reset)
      !active_valid_ff |-> idx_ff == '0)
      else $error("byte index not at zero while no frame is active");

   a_idx_in_frame : assert property (@(posedge clock) disable iff (reset)
      active_valid_ff |-> idx_ff <= last_idx)
      else $error("byte index ran past the end of the frame");

   a_drain_to_idle : assert property (@(posedge clock) disable iff (reset)
      (fire && is_last && !pend_valid) |=> !active_valid_ff)
      else $error("emitter stayed active after the final byte with nothing staged");

   a_next_frame_starts : assert property (@(posedge clock) disable iff (reset)
      (fire && is_last && pend_valid) |=> (active_valid_ff && idx_ff == '0))
      else $error("staged frame did not start straight after the final byte");

endmodule

`default_nettype wire

>>> rtl/core/telemetry_frame_serializer.sv
// Top level of the telemetry frame serializer.
//
// Each request on req_if carries a mode bit and nine signed 16-bit values. Mode 0
// sends an attitude frame of 18 bytes built from values 0 to 5; mode 1 sends a
// motion frame of 24 bytes built from all nine values. The frame leaves on rsp_if
// one byte per response: A5, 5A, length, type, each value in sign-magnitude form
// high byte first, the checksum and AA, with last_byte set on the AA byte only.
// Nine encoding lanes convert the values in parallel and a merging stage forms the
// checksum into a one-frame staging register; the emitter then steps through the
// frame with a byte counter.
// An accepted frame passes through the staging register and the emitter's active-frame
// register before its first byte is offered. The byte counter delivers one byte
// per cycle while ready is high; if the receiver holds ready low, the current
// byte stays on rsp_if and the counter waits. A request staged behind the active
// frame follows with no gap. A new request is accepted while the previous frame
// is still being sent, as long as the staging register is free; once it is full,
// req_if.ready drops. Synchronous reset discards any staged or active frame.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_serializer (
   input  wire logic clock,
   input  wire logic reset,
   tfs_req_if.sink   req_if,
   tfs_rsp_if.source rsp_if
);
   import tfs_pkg::*;

   logic signed [15:0] in_value [LaneCount];
   word_type           lane_word [LaneCount];
   logic [7:0]         lane_sum [LaneCount];
   frame_type          pend_frame;
   logic               pend_valid;
   logic               take;

   assign in_value[0] = req_if.payload.value_0;
   assign in_value[1] = req_if.payload.value_1;
   assign in_value[2] = req_if.payload.value_2;
   assign in_value[3] = req_if.payload.value_3;
   assign in_value[4] = req_if.payload.value_4;
   assign in_value[5] = req_if.payload.value_5;
   assign in_value[6] = req_if.payload.value_6;
   assign in_value[7] = req_if.payload.value_7;
   assign in_value[8] = req_if.payload.value_8;

   for (genvar g = 0; g < LaneCount; g++) begin : g_lane
      tfs_lane u_lane (
         .value    (in_value[g]),
         .word     (lane_word[g]),
         .byte_sum (lane_sum[g])
      );
   end

   tfs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .lane_word  (lane_word),
      .lane_sum   (lane_sum),
      .take       (take),
      .pend_frame (pend_frame),
      .pend_valid (pend_valid)
   );

   tfs_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .pend_frame (pend_frame),
      .pend_valid (pend_valid),
      .take       (take),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

>>> dv/tb_telemetry_frame_serializer.sv
// Self-checking testbench of the telemetry frame serializer, predicting every frame byte.
`timescale 1ns / 1ps

module tb_telemetry_frame_serializer;
   import tfs_pkg::*;

   localparam int RandomRequests = 120;
   localparam int ResetCycles    = 7;
   localparam int WatchdogLimit  = 3000;
   localparam int DrainCycles    = 40;
   localparam int LongHoldCycles = 300;
   localparam int LongHoldAfter  = 400;
   localparam int ReportLimit    = 10;

   logic clock;
   logic reset;

   tfs_req_if req_ch ();
   tfs_rsp_if rsp_ch ();

   telemetry_frame_serializer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   req_payload_type pending_requests[$];
   rsp_payload_type frame_bytes_due[$];

   int error_count    = 0;
   int bytes_seen     = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int hold_left      = 0;
   int phase_left     = 0;
   int idle_cycles    = 0;
   bit choppy_phase   = 1'b0;
   bit long_hold_done = 1'b0;

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic word_type sign_magnitude(logic signed [15:0] value);
      word_type raw;
      raw = word_type'(value);
      // The most negative value wraps round to zero here, as the frame format requires.
      if (raw[15]) return SignOffset + (16'h0000 - raw);
      return raw;
   endfunction

   function automatic void push_byte(logic [7:0] data, logic last);
      rsp_payload_type entry;
      entry.out_byte  = data;
      entry.last_byte = last;
      frame_bytes_due.push_back(entry);
   endfunction

   function automatic void push_frame(req_payload_type item);
      logic signed [15:0] values [LaneCount];
      word_type word;
      logic [7:0] length;
      logic [7:0] kind;
      logic [7:0] checksum;
      int count;
      values = '{item.value_0, item.value_1, item.value_2, item.value_3, item.value_4,
                 item.value_5, item.value_6, item.value_7, item.value_8};
      length   = (item.mode == ModeMotion) ? LenMot : LenAtt;
      kind     = (item.mode == ModeMotion) ? TypeMot : TypeAtt;
      count    = (item.mode == ModeMotion) ? LaneCount : AttCount;
      checksum = length + kind;
      push_byte(HdrFirst, 1'b0);
      push_byte(HdrSecond, 1'b0);
      push_byte(length, 1'b0);
      push_byte(kind, 1'b0);
      for (int i = 0; i < count; i++) begin
         word = sign_magnitude(values[i]);
         push_byte(word[15:8], 1'b0);
         push_byte(word[7:0], 1'b0);
         checksum = checksum + word[15:8] + word[7:0];
      end
      push_byte(checksum, 1'b0);
      push_byte(TailByte, 1'b1);
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sh8001;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_payload_type uniform_item(logic mode, logic signed [15:0] value);
      req_payload_type item;
      item.mode    = mode;
      item.value_0 = value;
      item.value_1 = value;
      item.value_2 = value;
      item.value_3 = value;
      item.value_4 = value;
      item.value_5 = value;
      item.value_6 = value;
      item.value_7 = value;
      item.value_8 = value;
      return item;
   endfunction

   // Sender: requests leave in bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            push_frame(req_ch.payload);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid   <= 1'b1;
               req_ch.payload <= pending_requests.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 10);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
         end
      end
   end

   // Receiver: checks each byte against the oldest prediction and drives its own stall pattern.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            bytes_seen++;
            if (frame_bytes_due.size() == 0) begin
               error_count++;
               if (error_count <= ReportLimit) begin
                  $display("ERROR: unexpected byte %0d: out_byte %h last_byte %b", bytes_seen,
                           rsp_ch.payload.out_byte, rsp_ch.payload.last_byte);
               end
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_ch.payload.out_byte !== want.out_byte ||
                   rsp_ch.payload.last_byte !== want.last_byte) begin
                  error_count++;
                  if (error_count <= ReportLimit) begin
                     $display("ERROR: byte %0d: expected out_byte %h last_byte %b, got %h %b",
                              bytes_seen, want.out_byte, want.last_byte,
                              rsp_ch.payload.out_byte, rsp_ch.payload.last_byte);
                  end
               end
            end
         end
         // One long hold-off, so that the staging register fills and request ready drops.
         if (!long_hold_done && bytes_seen >= LongHoldAfter) begin
            long_hold_done = 1'b1;
            hold_left      = LongHoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               choppy_phase = 1'($urandom_range(0, 1));
               phase_left   = $urandom_range(10, 80);
            end else begin
               phase_left--;
            end
            rsp_ch.ready <= choppy_phase ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_payload_type item;

      // Extremes of the values in both frame types, including the most negative value.
      pending_requests.push_back(uniform_item(ModeAttitude, 16'sd0));
      pending_requests.push_back(uniform_item(ModeAttitude, 16'sh7FFF));
      pending_requests.push_back(uniform_item(ModeAttitude, 16'sh8000));
      pending_requests.push_back(uniform_item(ModeAttitude, -16'sd1));
      pending_requests.push_back(uniform_item(ModeAttitude, 16'sd1));
      pending_requests.push_back(uniform_item(ModeMotion, 16'sd0));
      pending_requests.push_back(uniform_item(ModeMotion, 16'sh7FFF));
      pending_requests.push_back(uniform_item(ModeMotion, 16'sh8000));
      pending_requests.push_back(uniform_item(ModeMotion, -16'sd1));
      pending_requests.push_back(uniform_item(ModeMotion, 16'sh5555));
      pending_requests.push_back(uniform_item(ModeMotion, 16'shAAAA));

      // Mixed signs; the three motion-only values must be ignored in an attitude frame.
      item.mode    = ModeAttitude;
      item.value_0 = 16'sh8001;
      item.value_1 = -16'sd256;
      item.value_2 = 16'sd255;
      item.value_3 = 16'sh8000;
      item.value_4 = 16'sd256;
      item.value_5 = 16'sd12345;
      item.value_6 = -16'sd1;
      item.value_7 = 16'sh7FFF;
      item.value_8 = 16'sh8000;
      pending_requests.push_back(item);
      item.mode = ModeMotion;
      pending_requests.push_back(item);

      for (int i = 0; i < RandomRequests; i++) begin
         item.mode    = 1'($urandom_range(0, 1));
         item.value_0 = pick_value();
         item.value_1 = pick_value();
         item.value_2 = pick_value();
         item.value_3 = pick_value();
         item.value_4 = pick_value();
         item.value_5 = pick_value();
         item.value_6 = pick_value();
         item.value_7 = pick_value();
         item.value_8 = pick_value();
         pending_requests.push_back(item);
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_requests.size() != 0 || req_ch.valid);
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> telemetry_frame_serializer.f
rtl/core/tfs_pkg.sv
rtl/core/tfs_if.sv
rtl/core/tfs_lane.sv
rtl/core/tfs_merge.sv
rtl/core/tfs_emit.sv
rtl/core/telemetry_frame_serializer.sv
dv/tb_telemetry_frame_serializer.sv
